@@ design/plwm_pkg.sv @@
package plwm_pkg;

  // defaults for the top-level parameters
  localparam int RING_DEPTH_DEF = 1024;
  localparam int CELLS_DEF      = 8;

  // command field widths, sized for the largest ring (65536 entries)
  localparam int LOC_W  = 16;
  localparam int FILL_W = 17;

  // configuration register indexes
  localparam int            CFG_IDX_W    = 2;
  localparam logic [1:0]    CFG_JUMP_THR = 2'd0;
  localparam logic [1:0]    CFG_WIN_SEC  = 2'd1;

  // event kinds
  localparam logic [2:0] KIND_FIRST  = 3'd0;
  localparam logic [2:0] KIND_ACCEPT = 3'd1;
  localparam logic [2:0] KIND_REJECT = 3'd2;
  localparam logic [2:0] KIND_RETX   = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;

  // broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic              clr;      // clear hit flags for a new search
    logic              rd_en;    // scan read strobe
    logic [LOC_W-1:0]  rd_addr;  // local scan address
    logic              wr_en;    // store a word
    logic [LOC_W-1:0]  wr_cell;  // target cell
    logic [LOC_W-1:0]  wr_addr;  // local store address
    logic [31:0]       key;      // search key and store data
    logic [FILL_W-1:0] fill;     // entries 0..fill-1 hold valid numbers
  } cell_cmd_t;

endpackage

@@ design/plwm_cell.sv @@
module plwm_cell #(
  parameter int BANK    = 128,
  parameter int BASE    = 0,
  parameter int CELL_ID = 0,
  parameter int LW      = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  plwm_pkg::cell_cmd_t cmd,
  input  logic                hit_in,
  output logic                hit_out
);
  import plwm_pkg::*;

  logic [31:0] mem [BANK];
  logic [31:0] rd_data;
  logic        rd_vld;
  logic        hit;
  logic [31:0] gaddr;

  // global entry number of the word being read
  assign gaddr = 32'(BASE) + 32'(cmd.rd_addr);

  // bank storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (cmd.wr_cell == LOC_W'(CELL_ID))) begin
      mem[cmd.wr_addr[LW-1:0]] <= cmd.key;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr[LW-1:0]];
    end
  end

  // sticky match flag, merged with the neighbor's flag each cycle
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en && (gaddr < 32'(cmd.fill));
      hit    <= hit | hit_in | (rd_vld && (rd_data == cmd.key));
    end
  end

  assign hit_out = hit;

endmodule

@@ design/packet_loss_window_monitor_unit.sv @@
// Packet loss window monitor.
// Input channel: one word per received packet (seq_number, packet_bytes,
// time_seconds), taken when in_valid is high and in_stall is low.
// Output channel: exactly one result word per packet (event_kind and the
// counters), taken when out_valid is high and out_stall is low.
// Config channel: cfg_index selects jump_threshold (0) or window_seconds (1);
// written when cfg_valid and cfg_ready are high. Write only while idle.
// The first packet and a window-closing packet go straight to the decision.
// A packet inside a window is searched against the ring of recent numbers:
// the row of CELLS cells scans its banks in parallel, one entry per cycle,
// then the hit flag ripples down the row before the decision is made.
// The result sits in an output register: a stalled receiver does not block
// the next input word, but a second result waits until the first is taken.
// Reset (synchronous) clears the window, counters and the ring fill count;
// ring contents need no clearing since only filled entries are compared.
module packet_loss_window_monitor_unit #(
  parameter int RING_DEPTH = plwm_pkg::RING_DEPTH_DEF,
  parameter int CELLS      = plwm_pkg::CELLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // packet input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    seq_number,
  input  logic [11:0]                    packet_bytes,
  input  logic [31:0]                    time_seconds,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     event_kind,
  output logic [31:0]                    gap_added,
  output logic [31:0]                    window_loss,
  output logic [31:0]                    window_span,
  output logic [31:0]                    window_bytes,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [plwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import plwm_pkg::*;

  localparam int BANK    = (RING_DEPTH + CELLS - 1) / CELLS;
  localparam int LW      = (BANK > 1) ? $clog2(BANK) : 1;
  localparam int CW      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW      = $clog2(RING_DEPTH);
  localparam int FW      = $clog2(RING_DEPTH + 1);
  localparam int DRAIN   = CELLS + 2;
  localparam int CNT_MAX = (BANK > DRAIN) ? BANK : DRAIN;
  localparam int CNTW    = $clog2(CNT_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t            state;
  logic [CNTW-1:0]   cnt;
  logic [15:0]       jump_threshold;
  logic [7:0]        window_seconds;
  logic [31:0]       cur_seq;
  logic [11:0]       cur_bytes;
  logic [31:0]       in_time_hold;
  logic              is_first;
  logic              is_report;
  logic              window_open;
  logic [31:0]       window_start_time;
  logic [31:0]       window_first_seq;
  logic [31:0]       byte_total;
  logic [31:0]       loss_total;
  logic [31:0]       last_seq;
  logic [IW-1:0]     ring_index;
  logic [CW-1:0]     wr_cell;
  logic [LW-1:0]     wr_local;
  logic [FW-1:0]     fill;
  logic [31:0]       mag;
  logic [31:0]       gap;

  logic              in_take;
  logic              decide_go;
  logic              do_open;
  logic              do_store;
  logic              rejected;
  logic              retx;
  logic [31:0]       diff;
  logic [FW-1:0]     fill_cand;
  cell_cmd_t         cmd;
  logic [CELLS:0]    hit_chain;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign decide_go = (state == S_DECIDE) && (!out_valid || !out_stall);

  // decision terms
  assign diff     = cur_seq - last_seq;
  assign retx     = hit_chain[CELLS];
  assign rejected = mag > {16'd0, jump_threshold};
  assign do_open  = is_first || is_report;
  assign do_store = decide_go && (do_open || (!retx && !rejected));
  assign fill_cand = do_open ? FW'(1) : (FW'(ring_index) + FW'(1));

  // command word for the cell row
  always_comb begin
    cmd         = '0;
    cmd.clr     = in_take;
    cmd.rd_en   = (state == S_SCAN);
    cmd.rd_addr = LOC_W'(cnt);
    cmd.wr_en   = do_store;
    cmd.wr_cell = do_open ? '0 : LOC_W'(wr_cell);
    cmd.wr_addr = do_open ? '0 : LOC_W'(wr_local);
    cmd.key     = cur_seq;
    cmd.fill    = FILL_W'(fill);
  end

  // row of search cells; hit flags pass down the chain
  assign hit_chain[0] = 1'b0;
  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    plwm_cell #(
      .BANK   (BANK),
      .BASE   (c * BANK),
      .CELL_ID(c),
      .LW     (LW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .hit_in (hit_chain[c]),
      .hit_out(hit_chain[c+1])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= 16'd200;
      window_seconds <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_JUMP_THR: jump_threshold <= cfg_data;
        CFG_WIN_SEC:  window_seconds <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input capture and distance terms
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_seq   <= seq_number;
      cur_bytes <= packet_bytes;
    end
    if (state == S_SCAN) begin
      mag <= diff[31] ? (32'd0 - diff) : diff;
      gap <= diff - 32'd1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      is_first  <= 1'b0;
      is_report <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            cnt       <= '0;
            is_first  <= !window_open;
            is_report <= window_open &&
                         ((time_seconds - window_start_time) > 32'(window_seconds));
            if (!window_open ||
                ((time_seconds - window_start_time) > 32'(window_seconds))) begin
              state <= S_DECIDE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt == CNTW'(BANK - 1)) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_DRAIN: begin
          if (cnt == CNTW'(DRAIN)) begin
            state <= S_DECIDE;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_DECIDE: begin
          if (decide_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window state and ring pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      window_open       <= 1'b0;
      window_start_time <= '0;
      window_first_seq  <= '0;
      byte_total        <= '0;
      loss_total        <= '0;
      last_seq          <= '0;
      ring_index        <= '0;
      wr_cell           <= '0;
      wr_local          <= '0;
      fill              <= '0;
    end else if (do_store) begin
      last_seq <= cur_seq;
      if (fill_cand > fill) begin
        fill <= fill_cand;
      end
      if (do_open) begin
        window_open       <= 1'b1;
        window_start_time <= in_time_hold;
        window_first_seq  <= cur_seq;
        byte_total        <= 32'(cur_bytes);
        loss_total        <= '0;
        ring_index        <= IW'(1);
        if (BANK == 1) begin
          wr_cell  <= CW'(1);
          wr_local <= '0;
        end else begin
          wr_cell  <= '0;
          wr_local <= LW'(1);
        end
      end else begin
        byte_total <= byte_total + 32'(cur_bytes);
        loss_total <= loss_total + gap;
        if (ring_index == IW'(RING_DEPTH - 1)) begin
          ring_index <= '0;
          wr_cell    <= '0;
          wr_local   <= '0;
        end else begin
          ring_index <= ring_index + IW'(1);
          if (wr_local == LW'(BANK - 1)) begin
            wr_cell  <= wr_cell + CW'(1);
            wr_local <= '0;
          end else begin
            wr_local <= wr_local + LW'(1);
          end
        end
      end
    end
  end

  // arrival time of the current word, kept for a window opening
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_time_hold <= time_seconds;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      gap_added    <= '0;
      window_loss  <= '0;
      window_span  <= '0;
      window_bytes <= '0;
      if (is_first) begin
        event_kind <= KIND_FIRST;
      end else if (is_report) begin
        event_kind   <= KIND_REPORT;
        window_loss  <= loss_total;
        window_span  <= cur_seq - window_first_seq + 32'd1;
        window_bytes <= byte_total;
      end else if (retx) begin
        event_kind <= KIND_RETX;
      end else if (rejected) begin
        event_kind <= KIND_REJECT;
      end else begin
        event_kind <= KIND_ACCEPT;
        gap_added  <= gap;
      end
    end
  end

endmodule

@@ sim/plwm_checker.sv @@
`timescale 1ns / 1ps

// Watches the packet, result and config channels of the loss monitor,
// predicts each result word and compares it field by field.
module plwm_checker #(
  parameter int RING = plwm_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] seq_number,
  input  logic [11:0] packet_bytes,
  input  logic [31:0] time_seconds,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  event_kind,
  input  logic [31:0] gap_added,
  input  logic [31:0] window_loss,
  input  logic [31:0] window_span,
  input  logic [31:0] window_bytes,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [plwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        drain_done,
  output int          pending,
  output int          fail_count
);
  import plwm_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] gap;
    logic [31:0] loss;
    logic [31:0] span;
    logic [31:0] bytes;
  } pkt_result_t;

  // predictor copy of the monitor state
  logic [15:0] jump_thr;
  logic [7:0]  win_sec;
  logic [31:0] seen_seq [RING];
  bit          seen_ok  [RING];
  int          slot;
  bit          win_open;
  logic [31:0] win_start, win_first, octet_acc, loss_sum;

  pkt_result_t expected_words [$];
  bit          leftover_done;

  task automatic report(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic start_window(input logic [31:0] s, input logic [11:0] b,
                              input logic [31:0] t);
    seen_seq[0] = s;
    seen_ok[0]  = 1'b1;
    win_start   = t;
    win_first   = s;
    octet_acc   = {20'd0, b};
    loss_sum    = '0;
    slot        = 1 % RING;
    win_open    = 1'b1;
  endtask

  // work out the result word for one accepted packet
  task automatic predict_packet(input logic [31:0] s, input logic [11:0] b,
                                input logic [31:0] t);
    pkt_result_t r;
    logic [31:0] last, diff, mag;
    bit          hit;
    int          prev;
    r = '0;
    if (!win_open) begin
      start_window(s, b, t);
      r.kind = KIND_FIRST;
    end else if (t - win_start <= {24'd0, win_sec}) begin
      hit = 0;
      for (int k = 0; k < RING; k++)
        if (seen_ok[k] && seen_seq[k] == s) hit = 1;
      if (hit) begin
        r.kind = KIND_RETX;
      end else begin
        prev = (slot + RING - 1) % RING;
        last = seen_seq[prev];
        diff = s - last;
        mag  = diff[31] ? (32'd0 - diff) : diff;
        if (mag > {16'd0, jump_thr}) begin
          r.kind = KIND_REJECT;
        end else begin
          seen_seq[slot] = s;
          seen_ok[slot]  = 1'b1;
          octet_acc      = octet_acc + {20'd0, b};
          r.gap          = s - last - 32'd1;
          loss_sum       = loss_sum + r.gap;
          slot           = (slot + 1) % RING;
          r.kind         = KIND_ACCEPT;
        end
      end
    end else begin
      r.loss  = loss_sum;
      r.span  = s - win_first + 32'd1;
      r.bytes = octet_acc;
      start_window(s, b, t);
      r.kind  = KIND_REPORT;
    end
    expected_words.push_back(r);
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    pkt_result_t e;
    if (rst) begin
      jump_thr  = 16'd200;
      win_sec   = 8'd1;
      foreach (seen_ok[k]) seen_ok[k] = 1'b0;
      slot      = 0;
      win_open  = 1'b0;
      win_start = '0;
      win_first = '0;
      octet_acc = '0;
      loss_sum  = '0;
      expected_words.delete();
      leftover_done = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_JUMP_THR: jump_thr = cfg_data;
          CFG_WIN_SEC:  win_sec  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_packet(seq_number, packet_bytes, time_seconds);
      // compare the taken result word against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          e = expected_words.pop_front();
          if (event_kind !== e.kind)
            report($sformatf("event_kind %0d, want %0d", event_kind, e.kind));
          if (gap_added !== e.gap)
            report($sformatf("gap_added %h, want %h", gap_added, e.gap));
          if (window_loss !== e.loss)
            report($sformatf("window_loss %h, want %h", window_loss, e.loss));
          if (window_span !== e.span)
            report($sformatf("window_span %h, want %h", window_span, e.span));
          if (window_bytes !== e.bytes)
            report($sformatf("window_bytes %h, want %h", window_bytes, e.bytes));
        end
      end
      if (drain_done && !leftover_done) begin
        leftover_done = 1;
        if (expected_words.size() != 0)
          report($sformatf("%0d result words never came", expected_words.size()));
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import plwm_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] seq_number = '0;
  logic [11:0] packet_bytes = '0;
  logic [31:0] time_seconds = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  event_kind;
  logic [31:0] gap_added, window_loss, window_span, window_bytes;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        drain_done = 0;
  int          pending, fail_count;

  // stimulus bookkeeping
  bit          no_idle = 0;
  bit          stim_done = 0;
  logic [31:0] cur_seq, cur_time;
  int          cur_thr, cur_win;

  always #5 clk = ~clk;

  packet_loss_window_monitor_unit dut (.*);

  plwm_checker chk (.*);

  task automatic send_word(input logic [31:0] s, input logic [11:0] b,
                           input logic [31:0] t);
    if (!no_idle && $urandom_range(99) < 26) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    seq_number   = s;
    packet_bytes = b;
    time_seconds = t;
    in_valid     = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_index = idx;
    cfg_data  = d;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // hold off until every result word is in and the block has settled
  task automatic wait_quiet();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // one random packet, mostly in-window traffic with small steps
  task automatic random_packet();
    logic [31:0] s, t;
    int          pick;
    pick = $urandom_range(99);
    t = cur_time + $urandom_range(0, cur_win);
    if (pick < 62) begin
      s = cur_seq + $urandom_range(1, 3);
      cur_seq = s;
    end else if (pick < 72) begin
      s = cur_seq - $urandom_range(0, 6);
    end else if (pick < 80) begin
      s = cur_seq + cur_thr + $urandom_range(1, 500);
      if ($urandom_range(1)) s = cur_seq - cur_thr - $urandom_range(1, 500);
    end else if (pick < 84) begin
      s = cur_seq - $urandom_range(0, cur_thr);
      cur_seq = s;
    end else if (pick < 92) begin
      t = cur_time + cur_win + $urandom_range(1, 5);
      s = cur_seq + $urandom_range(0, 20);
      cur_seq  = s;
      cur_time = t;
    end else begin
      s = $urandom;
      t = $urandom;
      cur_seq  = s;
      cur_time = t;
    end
    send_word(s, $urandom_range(0, 4095), t);
  endtask

  // receiver stall
  initial begin
    forever begin
      @(negedge clk);
      out_stall = !no_idle && ($urandom_range(99) < 26);
    end
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int thr_set [4] = '{0, 65535, 50, 1000};
    int win_set [4] = '{0, 255, 3, 2};
    repeat (4) @(negedge clk);
    rst = 0;

    // directed, at reset settings: threshold 200, window 1
    cur_thr = 200;
    cur_win = 1;
    send_word(32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);   // opens window
    send_word(32'h0000_0000, 12'h000, 32'h0000_0000);   // wraps seq and time
    send_word(32'hFFFF_FFFF, 12'h008, 32'h0000_0000);   // retransmit
    send_word(32'h8000_0000, 12'h100, 32'h0000_0000);   // far jump rejected
    send_word(32'h0000_0005, 12'h040, 32'h0000_0000);   // gap of four
    send_word(32'h0000_00CD, 12'h040, 32'h0000_0000);   // exactly at threshold
    send_word(32'h0000_0196, 12'h040, 32'h0000_0000);   // one past threshold
    send_word(32'h0000_00C0, 12'hAAA, 32'h0000_0000);   // step backwards
    send_word(32'h0000_0000, 12'h555, 32'h0000_0000);   // old entry, retransmit
    send_word(32'h0000_0010, 12'h008, 32'h0000_0002);   // closes window: report
    send_word(32'h0000_0011, 12'hFFF, 32'h0000_0003);   // elapsed one, still open
    send_word(32'h0000_0012, 12'hFFF, 32'h0000_0005);   // report
    send_word(32'h7FFF_FFFF, 12'h001, 32'h8000_0000);   // report, huge span
    send_word(32'h8000_0000, 12'h002, 32'h8000_0001);   // accept across sign bit
    send_word(32'h0000_0010, 12'h003, 32'h8000_0001);   // not in ring, far jump rejected
    cur_seq  = 32'h8000_0000;
    cur_time = 32'h8000_0001;
    wait_quiet();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        cur_thr = thr_set[ph-1];
        cur_win = win_set[ph-1];
        write_reg(CFG_JUMP_THR, cur_thr[15:0]);
        write_reg(CFG_WIN_SEC, {8'($urandom), cur_win[7:0]});
      end
      for (int i = 0; i < 280; i++) begin
        no_idle = (ph == 2 && i >= 60 && i < 200);
        random_packet();
      end
      no_idle = 0;
      wait_quiet();
    end

    drain_done = 1;
    repeat (3) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
